[rtl/four_point_spline_resampler_assert.svh]
// Assertion macros for the four-point spline resampler RTL.
// Used by files that include this header; expects clk and rst_n in scope.
`ifndef FOUR_POINT_SPLINE_RESAMPLER_ASSERT_SVH
`define FOUR_POINT_SPLINE_RESAMPLER_ASSERT_SVH

// same-cycle implication
`define FSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fsr_pkg.sv]
// Shared types and constants for the four-point spline resampler.
// No dependencies; imported by every module of the block.
`default_nettype none

package fsr_pkg;

    localparam int STEP_W      = 21;
    localparam int SAMPLE_W    = 16;
    localparam int RES_MAX     = 48;
    localparam int RES_CNT_W   = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_sample;
        logic                       in_final;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       run_end;
        logic                       stream_end;
    } out_t;

    // a oldest .. d newest (d is the sample of the request itself)
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic signed [SAMPLE_W-1:0] c;
        logic signed [SAMPLE_W-1:0] d;
    } win_t;

    typedef struct packed {
        win_t win;
        logic is_last;
    } item_t;

endpackage

`default_nettype wire

[rtl/fsr_front.sv]
// Front end: accepts source samples, keeps the sample window and count,
// and works out the emit limit of each request. Depends on fsr_pkg.
`default_nettype none

module fsr_front
    import fsr_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  src_valid,
    output logic                       src_ready,
    input  wire in_t                   src_data,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output item_t                      q_item,
    output logic [COUNT_BITS-1:0]      q_count,
    output logic [COUNT_BITS-1:0]      q_limit
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic signed [SAMPLE_W-1:0] recent_reg [3];
    logic [COUNT_BITS-1:0]      count_reg;
    logic                       push;

    assign src_ready = q_ready;
    assign q_valid   = src_valid;
    assign push      = src_valid && q_ready;

    always_comb
    begin
        q_item.win.a   = recent_reg[2];
        q_item.win.b   = recent_reg[1];
        q_item.win.c   = recent_reg[0];
        q_item.win.d   = src_data.in_sample;
        q_item.is_last = src_data.in_final;
        q_count        = count_reg;
        q_limit        = '0;
        // limit in whole samples: position must stay below it
        if (count_reg != COUNT_MAX)
        begin
            if (src_data.in_final)
                q_limit = count_reg + COUNT_BITS'(1);
            else if (count_reg != '0)
                q_limit = count_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg[0] <= '0;
            recent_reg[1] <= '0;
            recent_reg[2] <= '0;
            count_reg     <= '0;
        end
        else if (push)
        begin
            if (src_data.in_final)
            begin
                recent_reg[0] <= '0;
                recent_reg[1] <= '0;
                recent_reg[2] <= '0;
                count_reg     <= '0;
            end
            else
            begin
                recent_reg[2] <= recent_reg[1];
                recent_reg[1] <= recent_reg[0];
                recent_reg[0] <= src_data.in_sample;
                if (count_reg != COUNT_MAX)
                    count_reg <= count_reg + COUNT_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/fsr_queue.sv]
// Short request queue between front end and back end.
// Depends on fsr_pkg for its depth and pointer widths.
`default_nettype none

`include "four_point_spline_resampler_assert.svh"

module fsr_queue
    import fsr_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic [DATA_W-1:0]      pop_data
);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    `FSR_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

`default_nettype wire

[rtl/fsr_back.sv]
// Back end: step register, output position, blend arithmetic sequencer and
// the result register. Depends on fsr_pkg and the assertion macro header.
`default_nettype none

`include "four_point_spline_resampler_assert.svh"

module fsr_back
    import fsr_pkg::*;
#(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [STEP_W-1:0]     cfg_data,
    input  wire logic                  pop_valid,
    output logic                       pop_ready,
    input  wire item_t                 pop_item,
    input  wire logic [COUNT_BITS-1:0] pop_count,
    input  wire logic [COUNT_BITS-1:0] pop_limit,
    output logic                       dst_valid,
    input  wire logic                  dst_ready,
    output out_t                       dst_data
);

    localparam int POS_W   = COUNT_BITS + FRAC_BITS + 1;
    localparam int INT_W   = COUNT_BITS + 1;
    localparam int CLAMP_W = (FRAC_BITS + 5 > STEP_W) ? FRAC_BITS + 5 : STEP_W;
    localparam int PROD_W  = FRAC_BITS + 18;
    localparam int FG_W    = 2 * FRAC_BITS;
    localparam int DD_W    = 18;
    localparam int M_W     = 2 * FRAC_BITS + 19;
    localparam int N_W     = 2 * FRAC_BITS + 20;
    localparam int Q_W     = 24;

    localparam logic [CLAMP_W-1:0] STEP_ONE = CLAMP_W'(1) << FRAC_BITS;
    localparam logic [CLAMP_W-1:0] STEP_LO  = CLAMP_W'(1) << (FRAC_BITS - 4);
    localparam logic [CLAMP_W-1:0] STEP_HI  = CLAMP_W'(1) << (FRAC_BITS + 4);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        BL_HOLD,
        BL_LIN,
        BL_FOUR
    } blend_t;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [Q_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > Q_W'(32767))
            r = 16'sh7fff;
        else if (v < -Q_W'(32768))
            r = 16'sh8000;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    state_t                     state_reg, state_next;
    logic [CLAMP_W-1:0]         step_reg;
    logic [CLAMP_W-1:0]         step_use;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [RES_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                       last_reg, last_next;
    logic                       dst_valid_reg, dst_valid_next;
    out_t                       dst_data_reg;
    logic                       load_out;
    logic                       pop_last;

    logic [INT_W-1:0]           pos_int;
    logic [INT_W-1:0]           lim_ext;
    logic [INT_W-1:0]           cnt_ext;
    logic [POS_W-1:0]           pos_sum;
    logic                       has_out;
    logic                       more;

    logic [FRAC_BITS-1:0]       frac;
    logic [FRAC_BITS:0]         gfrac;
    logic signed [SAMPLE_W-1:0] op_x, op_y;
    blend_t                     mode;
    logic signed [DD_W-1:0]     dd;

    blend_t                     mode_reg;
    logic signed [SAMPLE_W-1:0] hold_reg;
    logic signed [PROD_W-1:0]   xg_reg, yf_reg;
    logic [FG_W-1:0]            fg_reg;
    logic signed [DD_W-1:0]     dd_reg;
    logic signed [PROD_W-1:0]   l_reg;
    logic signed [M_W-1:0]      m_reg;

    logic signed [N_W-1:0]      n_sum;
    logic signed [Q_W-1:0]      q_four, q_lin, q_sel;
    out_t                       res;

    // step clamp to 1/16 .. 16
    always_comb
    begin
        step_use = step_reg;
        if (step_reg < STEP_LO)
            step_use = STEP_LO;
        else if (step_reg > STEP_HI)
            step_use = STEP_HI;
    end

    assign pos_int = pos_reg[POS_W-1:FRAC_BITS];
    assign lim_ext = {1'b0, pop_limit};
    assign cnt_ext = {1'b0, pop_count};
    assign has_out = (pos_int < lim_ext);
    assign pos_sum = pos_reg + POS_W'(step_use);
    assign more    = (pos_sum[POS_W-1:FRAC_BITS] < lim_ext)
                     && (cnt_reg != RES_CNT_W'(RES_MAX - 1));

    assign frac  = pos_reg[FRAC_BITS-1:0];
    assign gfrac = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // classify the current position against the window
    always_comb
    begin
        if (pos_int == cnt_ext)
        begin
            mode = BL_HOLD;
            op_x = pop_item.win.c;
            op_y = pop_item.win.d;
        end
        else if (pos_int + INT_W'(1) == cnt_ext)
        begin
            mode = BL_LIN;
            op_x = pop_item.win.c;
            op_y = pop_item.win.d;
        end
        else if (pop_count == COUNT_BITS'(2))
        begin
            mode = BL_LIN;
            op_x = pop_item.win.b;
            op_y = pop_item.win.c;
        end
        else
        begin
            mode = BL_FOUR;
            op_x = pop_item.win.b;
            op_y = pop_item.win.c;
        end
    end

    assign dd = DD_W'($signed(pop_item.win.b)) - DD_W'($signed(pop_item.win.a))
              + DD_W'($signed(pop_item.win.c)) - DD_W'($signed(pop_item.win.d));

    // rounding stage: truncate toward zero
    always_comb
    begin
        n_sum  = (N_W'(l_reg) <<< FRAC_BITS) + N_W'(m_reg);
        q_four = Q_W'($signed(n_sum[N_W-1:2*FRAC_BITS]))
               + ((n_sum[N_W-1] && (n_sum[2*FRAC_BITS-1:0] != '0)) ? Q_W'(1) : Q_W'(0));
        q_lin  = Q_W'($signed(l_reg[PROD_W-1:FRAC_BITS]))
               + ((l_reg[PROD_W-1] && (l_reg[FRAC_BITS-1:0] != '0)) ? Q_W'(1) : Q_W'(0));
        unique case (mode_reg)
            BL_FOUR: q_sel = q_four;
            BL_LIN:  q_sel = q_lin;
            BL_HOLD: q_sel = Q_W'(hold_reg);
            default: q_sel = Q_W'(hold_reg);
        endcase
        res.out_sample = sat16(q_sel);
        res.run_end    = last_reg;
        res.stream_end = last_reg && pop_item.is_last;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        pop_ready      = 1'b0;
        load_out       = 1'b0;
        dst_valid_next = dst_valid_reg && !dst_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    if (has_out)
                        state_next = ST_MUL;
                    else
                    begin
                        pop_ready = 1'b1;
                        if (pop_item.is_last)
                            pos_next = '0;
                    end
                end
            end
            ST_MUL:
            begin
                pos_next   = pos_sum;
                cnt_next   = cnt_reg + RES_CNT_W'(1);
                last_next  = !more;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!dst_valid_reg || dst_ready)
                begin
                    load_out       = 1'b1;
                    dst_valid_next = 1'b1;
                    if (last_reg)
                    begin
                        pop_ready  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                        if (pop_item.is_last)
                            pos_next = '0;
                    end
                    else
                        state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_ONE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            dst_valid_reg <= dst_valid_next;
            if (cfg_we)
                step_reg <= CLAMP_W'(cfg_data);
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            mode_reg <= mode;
            hold_reg <= pop_item.win.d;
            xg_reg   <= PROD_W'(op_x) * PROD_W'($signed({1'b0, gfrac - (FRAC_BITS+1)'(frac)}));
            yf_reg   <= PROD_W'(op_y) * PROD_W'($signed({1'b0, frac}));
            fg_reg   <= FG_W'(frac) * FG_W'(gfrac - (FRAC_BITS+1)'(frac));
            dd_reg   <= dd;
        end
        if (state_reg == ST_ADD)
        begin
            l_reg <= xg_reg + yf_reg;
            m_reg <= M_W'($signed({1'b0, fg_reg})) * M_W'(dd_reg);
        end
        if (load_out)
            dst_data_reg <= res;
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;
    assign pop_last  = pop_valid && pop_ready && pop_item.is_last;

    `FSR_ASSERT_NOW(a_busy_has_req, state_reg != ST_IDLE, pop_valid, "sequencer busy without request")
    `FSR_ASSERT_NOW(a_res_bound, 1'b1, cnt_reg <= RES_CNT_W'(RES_MAX), "result count past limit")
    `FSR_ASSERT_NEXT(a_end_clears_pos, pop_last, pos_reg == '0, "position not cleared at stream end")

endmodule

`default_nettype wire

[rtl/four_point_spline_resampler.sv]
// Top level of the four-point spline resampler: front end, request queue
// and back end. Depends on fsr_pkg, fsr_front, fsr_queue and fsr_back.
//
//   port group   | direction | handshake       | payload
//   src_*        | in        | valid / ready   | in_t   (in_sample, in_final)
//   dst_*        | out       | valid / ready   | out_t  (out_sample, run_end, stream_end)
//   cfg_*        | in        | write enable    | step_ratio, unsigned Q.16
//
// A request with no result is popped straight from the idle state of the sequencer.
// Each result passes through the multiply, add and round steps of the back-end
// sequencer in order; a request leaves the queue only when its last result is loaded.
// The front end takes requests while the 2-entry queue has room.
// A stalled dst channel holds the sequencer in its round step; no data is lost.
// Async rst_n clears window, count and position; the step returns to 1.0.
`default_nettype none

module four_point_spline_resampler
    import fsr_pkg::*;
#(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_ready,
    input  wire in_t               src_data,
    output logic                   dst_valid,
    input  wire logic              dst_ready,
    output out_t                   dst_data,
    input  wire logic              cfg_we,
    input  wire logic [STEP_W-1:0] cfg_data
);

    localparam int QDATA_W = 2 * COUNT_BITS + $bits(item_t);

    logic                  fq_valid, fq_ready;
    item_t                 fq_item;
    logic [COUNT_BITS-1:0] fq_count, fq_limit;
    logic                  qb_valid, qb_ready;
    logic [QDATA_W-1:0]    qb_data;
    item_t                 qb_item;
    logic [COUNT_BITS-1:0] qb_count, qb_limit;

    fsr_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_item    (fq_item),
        .q_count   (fq_count),
        .q_limit   (fq_limit)
    );

    fsr_queue #(
        .DATA_W (QDATA_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  ({fq_count, fq_limit, fq_item}),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    assign {qb_count, qb_limit, qb_item} = qb_data;

    fsr_back #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .pop_valid (qb_valid),
        .pop_ready (qb_ready),
        .pop_item  (qb_item),
        .pop_count (qb_count),
        .pop_limit (qb_limit),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data)
    );

endmodule

`default_nettype wire

[bench/four_point_spline_resampler_test.sv]
// Self-checking bench for four_point_spline_resampler: directed and random sample
// streams at many step settings, results checked against an in-bench interpolator.
// Depends on fsr_pkg and the resampler RTL.
module four_point_spline_resampler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fsr_pkg::*;

    localparam int     FRAC         = 16;
    localparam int     COUNT_W      = 24;
    localparam longint ONE          = 64'sd1 <<< FRAC;
    localparam longint STEP_LO      = ONE >>> 4;
    localparam longint STEP_HI      = ONE <<< 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int     LIMIT_CYCLES = 1_500_000;
    localparam int     SETTLE       = 16;
    localparam int     TAIL         = 200;
    localparam int     REPORT_MAX   = 10;
    localparam shortint EDGE_VALUES [4] = '{32767, -32768, 0, -1};

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG_STALL} rx_mode_e;
    typedef enum int {SRC_FULL, SRC_EXTREME, SRC_SMOOTH, SRC_TINY} src_style_e;
    typedef shortint pcm_list_t[$];

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              src_valid = 1'b0;
    logic              src_ready;
    in_t               src_data  = '0;
    logic              dst_valid;
    logic              dst_ready = 1'b0;
    out_t              dst_data;
    logic              cfg_we    = 1'b0;
    logic [STEP_W-1:0] cfg_data  = '0;

    // interpolator state, mirrors the block after reset
    logic [STEP_W-1:0]  step_reg = STEP_W'(ONE);
    shortint            hist [3] = '{0, 0, 0};   // newest first
    logic [COUNT_W-1:0] seen     = '0;
    logic [63:0]        position = '0;

    out_t        awaited[$];
    int          errors     = 0;
    int          burst_left = 0;
    int unsigned cycles     = 0;

    four_point_spline_resampler #(
        .COUNT_BITS (COUNT_W),
        .FRAC_BITS  (FRAC)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic shortint sat16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return shortint'(v);
    endfunction

    function automatic longint linear_blend(longint a, longint b, longint f);
        return (a * (ONE - f) + b * f) / ONE;   // truncates toward zero
    endfunction

    function automatic longint four_point_blend(longint a, longint b, longint c,
                                                longint d, longint f);
        longint g;
        longint num;
        g   = ONE - f;
        num = (b * g + c * f) * ONE + f * g * ((b - a) + (c - d));
        return num / (ONE * ONE);
    endfunction

    // Works out every result one accepted request causes and queues them.
    function automatic void interpolate_sample(in_t req);
        longint      w [4];
        logic [63:0] step;
        logic [63:0] n;
        logic [63:0] lim;
        logic [63:0] idx;
        logic [63:0] back;
        longint      f;
        longint      v;
        int          cnt;
        out_t        r;

        step = 64'(step_reg);
        if (step < STEP_LO)
            step = STEP_LO;
        if (step > STEP_HI)
            step = STEP_HI;
        n    = 64'(seen);
        w[0] = hist[2];
        w[1] = hist[1];
        w[2] = hist[0];
        w[3] = req.in_sample;

        lim = '0;
        if (seen != COUNT_MAX)
        begin
            if (req.in_final)
                lim = (n + 1) << FRAC;
            else if (n >= 1)
                lim = (n - 1) << FRAC;
        end

        cnt = 0;
        while (cnt < RES_MAX && position < lim)
        begin
            idx  = position >> FRAC;
            f    = longint'(position[FRAC-1:0]);
            back = (n >= idx) ? n - idx : 64'd0;
            if (back >= 2)
                v = (n == 2) ? linear_blend(w[1], w[2], f)
                             : four_point_blend(w[0], w[1], w[2], w[3], f);
            else if (back == 1)
                v = linear_blend(w[2], w[3], f);
            else
                v = w[3];
            r.out_sample = sat16(v);
            r.run_end    = 1'b0;
            r.stream_end = 1'b0;
            awaited.push_back(r);
            cnt++;
            position += step;
        end

        if (cnt > 0)
        begin
            r            = awaited.pop_back();
            r.run_end    = 1'b1;
            r.stream_end = req.in_final;
            awaited.push_back(r);
        end

        if (req.in_final)
        begin
            hist     = '{0, 0, 0};
            seen     = '0;
            position = '0;
        end
        else
        begin
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = req.in_sample;
            if (seen != COUNT_MAX)
                seen++;
        end
    endfunction

    function automatic void log_mismatch(string what, out_t want, out_t got);
        errors++;
        if (errors <= REPORT_MAX)
            $display("%0t %s: expected sample %0d run_end %0b stream_end %0b, got %0d %0b %0b",
                     $realtime, what, want.out_sample, want.run_end, want.stream_end,
                     got.out_sample, got.run_end, got.stream_end);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && dst_ready)
        begin
            if (awaited.size() == 0)
                log_mismatch("result with nothing awaited", '0, dst_data);
            else if (dst_data.out_sample !== awaited[0].out_sample
                     || dst_data.run_end !== awaited[0].run_end
                     || dst_data.stream_end !== awaited[0].stream_end)
                log_mismatch("result mismatch", awaited.pop_front(), dst_data);
            else
                void'(awaited.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: spans of open, random, periodic and long-stall backpressure.
    initial
    begin : dst_backpressure
        rx_mode_e mode;
        int       span;
        int       period;
        int       lo;
        int       stall;
        int       k;
        @(posedge rst_n);
        forever
        begin
            mode   = rx_mode_e'($urandom_range(0, 3));
            span   = $urandom_range(20, 150);
            period = $urandom_range(2, 6);
            lo     = $urandom_range(1, period - 1);
            stall  = $urandom_range(4, 12);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    RX_OPEN:     dst_ready <= 1'b1;
                    RX_RANDOM:   dst_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: dst_ready <= ((k % period) >= lo);
                    default:     dst_ready <= (k >= stall);
                endcase
            end
        end
    end

    // Entered and left just after a falling edge; valid stays high on return so a
    // following request can go out back to back.
    task automatic send_sample(input shortint smp, input bit fin);
        in_t req;
        int  gap;
        req.in_sample = smp;
        req.in_final  = fin;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                src_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        src_valid <= 1'b1;
        src_data  <= req;
        do
            @(posedge clk);
        while (!src_ready);
        interpolate_sample(req);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        src_valid <= 1'b0;
        while (awaited.size() != 0)
            @(negedge clk);
        // a request with no result may still be in the queue
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        step_reg  = value;
    endtask

    task automatic send_list(input pcm_list_t vals);
        int k;
        for (k = 0; k < vals.size(); k++)
            send_sample(vals[k], k == vals.size() - 1);
    endtask

    function automatic shortint pick_sample(src_style_e style, shortint prev);
        int t;
        case (style)
            SRC_EXTREME: return EDGE_VALUES[$urandom_range(0, 3)];
            SRC_SMOOTH:
            begin
                t = int'(prev) + int'($urandom_range(0, 4000)) - 2000;
                if (t > 32767)
                    t = 32767;
                if (t < -32768)
                    t = -32768;
                return shortint'(t);
            end
            SRC_TINY:    return shortint'(int'($urandom_range(0, 8)) - 4);
            default:     return shortint'($urandom());
        endcase
    endfunction

    task automatic send_stream(input int len, input src_style_e style);
        shortint s;
        int      k;
        s = pick_sample(SRC_FULL, 0);
        for (k = 0; k < len; k++)
        begin
            s = pick_sample(style, s);
            send_sample(s, k == len - 1);
        end
    endtask

    // Whole streams, mostly long enough to reach the four-point window.
    task automatic run_streams(input int budget, input int max_len);
        int left;
        int len;
        left = budget;
        while (left > 0)
        begin
            case ($urandom_range(0, 7))
                0:       len = 1;
                1:       len = 2;
                2:       len = 3;
                default: len = $urandom_range(4, max_len);
            endcase
            if (len > left)
                len = left;
            send_stream(len, src_style_e'($urandom_range(0, 3)));
            left -= len;
            if ($urandom_range(0, 9) == 0)
                wait_idle();
        end
    endtask

    // Reset step of 1.0: one-sample, two-sample and a full-scale stream.
    task automatic test_short_streams();
        pcm_list_t vals;
        vals = '{-32768};
        send_list(vals);
        vals = '{32767, -32768};
        send_list(vals);
        vals = '{-32768, 32767, 32767, -32768, 0, -1};
        send_list(vals);
    endtask

    // Step below range clamps to 1/16; full-scale steps overshoot both rails.
    task automatic test_overshoot_saturation();
        pcm_list_t vals;
        write_step('0);
        vals = '{32767, -32768, -32768, 32767, -32768};
        send_list(vals);
    endtask

    // Step above range clamps to 16; the final request then has no position left.
    task automatic test_final_without_output();
        pcm_list_t vals;
        write_step('1);
        vals = '{5, -7, 3, 100};
        send_list(vals);
    endtask

    // Step 1.5 on small and full-scale values of both signs: truncation toward zero.
    task automatic test_truncation();
        pcm_list_t vals;
        write_step(STEP_W'(98304));
        vals = '{-1, 1, -32768, 32767, -3, 3, -2};
        send_list(vals);
    endtask

    task automatic test_upsampling();
        int p;
        write_step(STEP_W'(STEP_LO));
        run_streams(35, 30);
        for (p = 0; p < 2; p++)
        begin
            write_step(STEP_W'($urandom_range(STEP_LO, ONE - 1)));
            run_streams(35, 30);
        end
    endtask

    task automatic test_downsampling();
        int p;
        write_step(STEP_W'(STEP_HI));
        run_streams(30, 60);
        for (p = 0; p < 3; p++)
        begin
            write_step(STEP_W'($urandom_range(ONE, STEP_HI)));
            run_streams(30, 60);
        end
    endtask

    task automatic test_clamped_steps();
        write_step(STEP_W'(STEP_LO - 1));
        run_streams(12, 20);
        write_step(STEP_W'(STEP_HI + 1));
        run_streams(12, 40);
        write_step('0);
        run_streams(12, 20);
        write_step('1);
        run_streams(12, 40);
        write_step(STEP_W'($urandom()));
        run_streams(12, 40);
    endtask

    task automatic test_mixed_steps();
        write_step(STEP_W'(ONE));
        run_streams(25, 40);
        write_step(STEP_W'($urandom_range(STEP_LO, STEP_HI)));
        run_streams(25, 40);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_short_streams();
        test_overshoot_saturation();
        test_final_without_output();
        test_truncation();
        test_upsampling();
        test_downsampling();
        test_clamped_steps();
        test_mixed_steps();

        wait_idle();
        repeat (TAIL) @(negedge clk);
        if (errors == 0 && awaited.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
